### hdl/pbd_pkg.sv
package pbd_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] corner_a_x;
        logic signed [31:0] corner_a_y;
        logic signed [31:0] corner_a_z;
        logic signed [31:0] corner_b_x;
        logic signed [31:0] corner_b_y;
        logic signed [31:0] corner_b_z;
    } t_pbd_in;

    typedef struct packed {
        logic [32:0] distance;
        logic        used_corner;
    } t_pbd_out;

    localparam int DIST_BITS = 33;

endpackage

### hdl/pbd_front.sv
// per-axis bounds, inside test, near distance, then squares
module pbd_front import pbd_pkg::*; #(
    parameter int CB = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_pbd_in           i_item,
    output logic              o_valid,
    output logic [2:0]        o_inside,
    output logic [3*CB-1:0]   o_near,
    output logic [2*CB+1:0]   o_sumsq
);
    logic signed [CB-1:0] p [3], ca [3], cb [3];
    logic [CB-1:0] n_near [3];
    logic [2:0]    n_inside;
    logic [CB-1:0] r_near [3];
    logic [2:0]    r_inside;
    logic          r_v1, r_v2;
    logic [2*CB-1:0] r_sq [3];
    logic [2:0]    r_inside2;
    logic [3*CB-1:0] r_near2;

    // low CB bits of each zero-extended field, top bit is the sign
    assign p[0] = CB'({32'd0, i_item.point_x});
    assign p[1] = CB'({32'd0, i_item.point_y});
    assign p[2] = CB'({32'd0, i_item.point_z});
    assign ca[0] = CB'({32'd0, i_item.corner_a_x});
    assign ca[1] = CB'({32'd0, i_item.corner_a_y});
    assign ca[2] = CB'({32'd0, i_item.corner_a_z});
    assign cb[0] = CB'({32'd0, i_item.corner_b_x});
    assign cb[1] = CB'({32'd0, i_item.corner_b_y});
    assign cb[2] = CB'({32'd0, i_item.corner_b_z});

    // sort bounds and take the nearer bound per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [CB-1:0] lo, hi;
            logic [CB:0] dl, dh;
            lo = (ca[a] < cb[a]) ? ca[a] : cb[a];
            hi = (ca[a] < cb[a]) ? cb[a] : ca[a];
            n_inside[a] = (p[a] >= lo) && (p[a] <= hi);
            dl = (p[a] >= lo) ? ({p[a][CB-1], p[a]} - {lo[CB-1], lo})
                              : ({lo[CB-1], lo} - {p[a][CB-1], p[a]});
            dh = (p[a] >= hi) ? ({p[a][CB-1], p[a]} - {hi[CB-1], hi})
                              : ({hi[CB-1], hi} - {p[a][CB-1], p[a]});
            // the nearer distance never exceeds 2^CB-1, so CB bits hold it
            n_near[a] = (dl < dh) ? dl[CB-1:0] : dh[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_inside <= n_inside;
        for (int a = 0; a < 3; a++) r_near[a] <= n_near[a];
        // squares
        for (int a = 0; a < 3; a++) r_sq[a] <= r_near[a] * r_near[a];
        r_inside2 <= r_inside;
        r_near2 <= {r_near[2], r_near[1], r_near[0]};
    end

    assign o_valid  = r_v2;
    assign o_inside = r_inside2;
    assign o_near   = r_near2;
    assign o_sumsq  = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
endmodule

### hdl/pbd_cell.sv
// one restoring square-root digit; also carries face result along the chain
module pbd_cell #(
    parameter int RB = 34,
    parameter int SB = 68,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [RB-1:0] i_root,
    input  logic [SB-1:0] i_rem,
    input  logic          i_found,
    input  logic [RB-1:0] i_best,
    output logic          o_valid,
    output logic [RB-1:0] o_root,
    output logic [SB-1:0] o_rem,
    output logic          o_found,
    output logic [RB-1:0] o_best
);
    logic [SB-1:0] w_trial;
    logic [SB-1:0] w_root_ext;
    logic          r_valid, r_found;
    logic [RB-1:0] r_root, r_best;
    logic [SB-1:0] r_rem;

    // trial subtract (2*root + 2^bit) << bit
    assign w_root_ext = {{(SB-RB){1'b0}}, i_root};
    assign w_trial = ((w_root_ext << 1) | (SB'(1) << BIT)) << BIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_found <= i_found;
        r_best  <= i_best;
        if (i_rem >= w_trial) begin
            r_rem  <= i_rem - w_trial;
            r_root <= i_root | (RB'(1) << BIT);
        end else begin
            r_rem  <= i_rem;
            r_root <= i_root;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;
    assign o_rem   = r_rem;
    assign o_found = r_found;
    assign o_best  = r_best;
endmodule

### hdl/point_box_distance_unit.sv
// Point to box distance, fully pipelined: one item per cycle. Each result is
// strobed on o_done after the front registers, the face-selection register,
// the chain of square-root cells (one root bit per cell) and the output
// register. busy is always low; results are strobed on o_done for one cycle
// and cannot be held off.
module point_box_distance_unit import pbd_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_pbd_in  i_item,
    output logic     o_done,
    output t_pbd_out o_result
);
    localparam int RB = COORD_BITS + 2;
    localparam int SB = 2 * COORD_BITS + 4;
    localparam int NC = COORD_BITS + 1;

    logic             f_valid;
    logic [2:0]       f_inside;
    logic [3*COORD_BITS-1:0] f_near;
    logic [2*COORD_BITS+1:0] f_sumsq;
    logic             r_valid;
    logic             r_found;
    logic [RB-1:0]    r_best;
    logic [SB-1:0]    r_rem;
    logic             n_found;
    logic [RB-1:0]    n_best;
    logic             r_out_v;
    t_pbd_out         r_out;

    logic          c_valid [NC+1];
    logic [RB-1:0] c_root  [NC+1];
    logic [SB-1:0] c_rem   [NC+1];
    logic          c_found [NC+1];
    logic [RB-1:0] c_best  [NC+1];

    assign busy = 1'b0;

    pbd_front #(.CB(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start & i_rst_n), .i_item(i_item),
        .o_valid(f_valid), .o_inside(f_inside), .o_near(f_near), .o_sumsq(f_sumsq)
    );

    // face selection
    always_comb begin
        logic [COORD_BITS-1:0] nr [3];
        n_found = 1'b0;
        n_best  = '0;
        for (int a = 0; a < 3; a++) begin
            nr[a] = f_near[a*COORD_BITS +: COORD_BITS];
        end
        for (int a = 0; a < 3; a++) begin
            if (f_inside[(a+1)%3] && f_inside[(a+2)%3]) begin
                if (!n_found || RB'(nr[a]) < n_best) n_best = RB'(nr[a]);
                n_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= f_valid;
        end
        r_found <= n_found;
        r_best  <= n_best;
        r_rem   <= SB'(f_sumsq);
    end

    assign c_valid[0] = r_valid;
    assign c_root[0]  = '0;
    assign c_rem[0]   = r_rem;
    assign c_found[0] = r_found;
    assign c_best[0]  = r_best;

    // root chain, msb first
    for (genvar g = 0; g < NC; g++) begin : g_cell
        pbd_cell #(.RB(RB), .SB(SB), .BIT(NC-1-g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(c_valid[g]), .i_root(c_root[g]), .i_rem(c_rem[g]),
            .i_found(c_found[g]), .i_best(c_best[g]),
            .o_valid(c_valid[g+1]), .o_root(c_root[g+1]), .o_rem(c_rem[g+1]),
            .o_found(c_found[g+1]), .o_best(c_best[g+1])
        );
    end

    // output register with saturation
    always_ff @(posedge i_clk) begin
        logic [RB-1:0] v;
        v = c_found[NC] ? c_best[NC] : c_root[NC];
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= c_valid[NC];
        end
        r_out.used_corner <= ~c_found[NC];
        if (v > RB'({DIST_BITS{1'b1}})) r_out.distance <= {DIST_BITS{1'b1}};
        else r_out.distance <= DIST_BITS'(v);
    end

    assign o_done   = r_out_v;
    assign o_result = r_out;
endmodule

### hdl/pbd_checker.sv
module pbd_checker import pbd_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_done,
    input t_pbd_out o_result
);
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_no_done_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("done after reset");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_result))
        else $error("unknown result");
    a_start_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(start))
        else $error("unknown start");
endmodule

bind point_box_distance_unit pbd_checker u_pbd_checker (.*);
